@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the sorted deadline timer queue.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SDTQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define SDTQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define SDTQ_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SDTQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/sdtq_pkg.sv @@
// Package of the sorted deadline timer queue: item types, codes, cell types.
// No dependencies.
`timescale 1ns / 1ps
package sdtq_pkg;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] timer_tag;
      logic [31:0] deadline_s;
      logic [31:0] repeat_ms;
      logic [31:0] now_s;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] expired_tag;
      logic [31:0] next_deadline_s;
      logic        has_pending;
      logic [4:0]  pending_count;
      logic        last;
   } rsp_item_type;

   localparam logic [1:0] OP_ARM    = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [2:0] KIND_ARMED     = 3'd0;
   localparam logic [2:0] KIND_CANCELLED = 3'd1;
   localparam logic [2:0] KIND_NOT_FOUND = 3'd2;
   localparam logic [2:0] KIND_FULL      = 3'd3;
   localparam logic [2:0] KIND_EXPIRED   = 3'd4;
   localparam logic [2:0] KIND_NONE      = 3'd5;

   localparam int RESULT_CAP = 16;
   localparam int RES_CNT_W  = 5;

   // ms -> s rounding: (ms + 500) / 1000 == ((ms + 500) >> 3) / 125,
   // the divide by 125 done as a multiply by a 38-bit reciprocal
   localparam logic [32:0] DIV_ROUND_ADD = 33'd500;
   localparam int          RECIP_SHIFT   = 44;
   localparam logic [37:0] RECIP_M       =
      38'(((64'd1 << RECIP_SHIFT) / 64'd125) + 64'd1);
   localparam logic [18:0] RECIP_LO      = RECIP_M[18:0];
   localparam logic [18:0] RECIP_HI      = RECIP_M[37:19];

   typedef struct packed {
      logic [31:0] dl;
      logic [31:0] sec;
      logic        rep;
      logic        fired;
      logic        valid;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        by_tag;
      entry_type   key;
   } cell_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_INSERT,
      ST_CANCEL,
      ST_FIND,
      ST_REMOVE,
      ST_REINSERT,
      ST_EMIT
   } state_type;

   // wrap-aware: a is later than b when a-b is positive as signed
   function automatic logic is_later(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d != 32'd0) && !d[31];
   endfunction

endpackage

@@ rtl/sdtq_div.sv @@
// Rounding ms-to-seconds converter by a registered reciprocal multiply.
// Depends on sdtq_pkg.
`timescale 1ns / 1ps
module sdtq_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] ms,
   output logic        done,
   output logic [31:0] sec
);
   import sdtq_pkg::*;

   logic [32:0] rounded;
   logic [67:0] total;
   logic [29:0] y_ff;
   logic [48:0] lo_ff, hi_ff;
   logic [23:0] q_ff;
   logic        mul_ff, sum_ff, done_ff;

   // round, then drop the factor of 8 so only /125 is left
   assign rounded = {1'b0, ms} + DIV_ROUND_ADD;
   assign total   = {hi_ff, 19'd0} + {19'd0, lo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         sum_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= start;
         sum_ff  <= mul_ff;
         done_ff <= sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) y_ff <= rounded[32:3];
      lo_ff <= 49'(y_ff) * 49'(RECIP_LO);
      hi_ff <= 49'(y_ff) * 49'(RECIP_HI);
      q_ff  <= total[67:RECIP_SHIFT];
   end

   assign done = done_ff;
   assign sec  = 32'(q_ff);

endmodule

@@ rtl/sdtq_cell.sv @@
// One slot of the sorted timer chain; shifts with its neighbors on insert/remove.
// Depends on sdtq_pkg.
`timescale 1ns / 1ps
module sdtq_cell #(
   parameter int TAG_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sdtq_pkg::cell_cmd_type cmd,
   input  logic [TAG_BITS-1:0]   key_tag,
   input  sdtq_pkg::entry_type   left_entry,
   input  logic [TAG_BITS-1:0]   left_tag,
   input  sdtq_pkg::entry_type   right_entry,
   input  logic [TAG_BITS-1:0]   right_tag,
   input  logic                  ins_in,
   output logic                  ins_out,
   input  logic                  rm_in,
   output logic                  rm_out,
   output logic                  sel,
   output sdtq_pkg::entry_type   entry_out,
   output logic [TAG_BITS-1:0]   tag_out
);
   import sdtq_pkg::*;

   entry_type           ent_ff, ent_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic                later, hit;

   always_comb begin
      later   = !ent_ff.valid || is_later(ent_ff.dl, cmd.key.dl);
      hit     = ent_ff.valid && (cmd.by_tag ? (tag_ff == key_tag) : !ent_ff.fired);
      ins_out = ins_in | later;
      rm_out  = rm_in | hit;
      sel     = hit & !rm_in;
      ent_in  = ent_ff;
      tag_in  = tag_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (ins_in) begin
               ent_in = left_entry;
               tag_in = left_tag;
            end else if (later) begin
               ent_in = cmd.key;
               tag_in = key_tag;
            end
         end
         CELL_REMOVE: begin
            if (rm_in | hit) begin
               ent_in = right_entry;
               tag_in = right_tag;
            end
         end
         CELL_CLEAR: ent_in.fired = 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff <= '0;
         tag_ff <= '0;
      end else begin
         ent_ff <= ent_in;
         tag_ff <= tag_in;
      end
   end

   assign entry_out = ent_ff;
   assign tag_out   = tag_ff;

endmodule

@@ rtl/sorted_deadline_timer_queue.sv @@
// Sorted deadline timer queue. Up to MAX_TIMERS timers sit in a row of cells
// ordered by deadline (wrap-aware seconds); arm inserts behind equal
// deadlines, cancel drops the first tag match, tick fires expired timers in
// order and re-queues repeating ones at deadline + round(repeat_ms/1000).
// One item is worked at a time; req_stall is high until its last result is
// in the output register; output backpressure holds the emit step. An arm
// rounds by a reciprocal multiply, then does one chain insert; a full arm
// only emits; a tick clears fired marks, then for each fired timer does a
// chain remove, a chain insert if repeating, find and emit, with at most
// 16 fired per tick.
// Depends on sdtq_pkg, sdtq_cell, sdtq_div.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sorted_deadline_timer_queue #(
   parameter int MAX_TIMERS = 16,
   parameter int TAG_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sdtq_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sdtq_pkg::rsp_item_type rsp_data
);
   import sdtq_pkg::*;

   localparam int CNT_W = $clog2(MAX_TIMERS + 1);

   state_type           state_ff, state_nx;
   req_item_type        req_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [RES_CNT_W-1:0] n_ff;
   logic [2:0]          res_kind_ff;
   logic [15:0]         res_tag_ff;
   logic                res_last_ff;
   logic [31:0]         cur_dl_ff, cur_sec_ff;
   logic [TAG_BITS-1:0] cur_tag_ff;
   logic                rsp_valid_ff;
   rsp_item_type        rsp_ff;

   // chain wiring
   cell_cmd_type        cmd;
   logic [TAG_BITS-1:0] key_tag;
   entry_type           ent_w [MAX_TIMERS];
   logic [TAG_BITS-1:0] tag_w [MAX_TIMERS];
   logic [MAX_TIMERS:0] ins_c, rm_c;
   logic [MAX_TIMERS-1:0] sel_w;

   // first-hit selection
   logic [31:0]         sel_dl, sel_sec;
   logic                sel_rep;
   logic [TAG_BITS-1:0] sel_tag;
   logic                any_hit, fire, accept, emit_go, full;
   logic                div_done;
   logic [31:0]         div_sec;
   logic [63:0]         req_tag_wide, sel_tag_wide;
   logic [31:0]         cnt_wide;

   assign accept  = req_valid && !req_stall;
   assign any_hit = rm_c[MAX_TIMERS];
   assign full    = count_ff == CNT_W'(MAX_TIMERS);
   assign emit_go = !rsp_valid_ff || !rsp_stall;

   assign req_tag_wide = 64'(req_ff.timer_tag);

   sdtq_div u_div (
      .clock (clock),
      .reset (reset),
      .start (accept && req_data.op == OP_ARM && !full),
      .ms    (req_data.repeat_ms),
      .done  (div_done),
      .sec   (div_sec)
   );

   assign ins_c[0] = 1'b0;
   assign rm_c[0]  = 1'b0;

   for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_cell
      entry_type           l_ent, r_ent;
      logic [TAG_BITS-1:0] l_tag, r_tag;
      if (i == 0) begin : g_first
         assign l_ent = '0;
         assign l_tag = '0;
      end else begin : g_mid
         assign l_ent = ent_w[i-1];
         assign l_tag = tag_w[i-1];
      end
      if (i == MAX_TIMERS - 1) begin : g_last
         assign r_ent = '0;
         assign r_tag = '0;
      end else begin : g_inner
         assign r_ent = ent_w[i+1];
         assign r_tag = tag_w[i+1];
      end
      sdtq_cell #(.TAG_BITS(TAG_BITS)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .key_tag     (key_tag),
         .left_entry  (l_ent),
         .left_tag    (l_tag),
         .right_entry (r_ent),
         .right_tag   (r_tag),
         .ins_in      (ins_c[i]),
         .ins_out     (ins_c[i+1]),
         .rm_in       (rm_c[i]),
         .rm_out      (rm_c[i+1]),
         .sel         (sel_w[i]),
         .entry_out   (ent_w[i]),
         .tag_out     (tag_w[i])
      );
   end

   // AND-OR pick of the first unfired (or tag-matching) entry
   always_comb begin
      sel_dl  = '0;
      sel_sec = '0;
      sel_rep = 1'b0;
      sel_tag = '0;
      for (int i = 0; i < MAX_TIMERS; i++) begin
         if (sel_w[i]) begin
            sel_dl  = sel_dl | ent_w[i].dl;
            sel_sec = sel_sec | ent_w[i].sec;
            sel_rep = sel_rep | ent_w[i].rep;
            sel_tag = sel_tag | tag_w[i];
         end
      end
   end

   assign sel_tag_wide = 64'(sel_tag);
   assign fire = any_hit && !is_later(sel_dl, req_ff.now_s) &&
                 (n_ff < RES_CNT_W'(RESULT_CAP));

   // next state
   always_comb begin
      state_nx = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.op)
                  OP_ARM:    state_nx = full ? ST_EMIT : ST_DIV;
                  OP_CANCEL: state_nx = ST_CANCEL;
                  OP_TICK:   state_nx = ST_FIND;
                  default:   state_nx = ST_IDLE;
               endcase
            end
         end
         ST_DIV:      if (div_done) state_nx = ST_INSERT;
         ST_INSERT:   state_nx = ST_EMIT;
         ST_CANCEL:   state_nx = ST_EMIT;
         ST_FIND:     state_nx = (n_ff == '0 && fire) ? ST_REMOVE : ST_EMIT;
         ST_REMOVE:   state_nx = sel_rep ? ST_REINSERT : ST_FIND;
         ST_REINSERT: state_nx = ST_FIND;
         ST_EMIT:     if (emit_go) state_nx = res_last_ff ? ST_IDLE : ST_REMOVE;
         default:     state_nx = ST_IDLE;
      endcase
   end

   // chain command per state
   always_comb begin
      cmd           = '0;
      cmd.op        = CELL_HOLD;
      cmd.key.valid = 1'b1;
      key_tag       = req_tag_wide[TAG_BITS-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.op == OP_TICK) cmd.op = CELL_CLEAR;
         end
         ST_INSERT: begin
            cmd.op      = CELL_INSERT;
            cmd.key.dl  = req_ff.deadline_s;
            cmd.key.sec = div_sec;
            cmd.key.rep = req_ff.repeat_ms != 32'd0;
         end
         ST_CANCEL: begin
            cmd.op     = CELL_REMOVE;
            cmd.by_tag = 1'b1;
         end
         ST_REMOVE:   cmd.op = CELL_REMOVE;
         ST_REINSERT: begin
            cmd.op        = CELL_INSERT;
            cmd.key.dl    = cur_dl_ff + cur_sec_ff;
            cmd.key.sec   = cur_sec_ff;
            cmd.key.rep   = 1'b1;
            cmd.key.fired = 1'b1;
            key_tag       = cur_tag_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         n_ff         <= '0;
         res_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_nx;
         // the emit state sets the output register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_EMIT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  req_ff      <= req_data;
                  n_ff        <= '0;
                  res_kind_ff <= KIND_FULL;
                  res_tag_ff  <= '0;
                  res_last_ff <= 1'b1;
               end
            end
            ST_INSERT: begin
               count_ff    <= count_ff + 1'b1;
               res_kind_ff <= KIND_ARMED;
            end
            ST_CANCEL: begin
               if (any_hit) count_ff <= count_ff - 1'b1;
               res_kind_ff <= any_hit ? KIND_CANCELLED : KIND_NOT_FOUND;
            end
            ST_FIND: begin
               // result of the previous firing is final unless another fires
               if (n_ff == '0) begin
                  res_kind_ff <= KIND_NONE;
                  res_last_ff <= 1'b1;
               end else begin
                  res_kind_ff <= KIND_EXPIRED;
                  res_last_ff <= !fire;
               end
            end
            ST_REMOVE: begin
               cur_dl_ff  <= sel_dl;
               cur_sec_ff <= sel_sec;
               cur_tag_ff <= sel_tag;
               res_tag_ff <= sel_tag_wide[15:0];
               count_ff   <= count_ff - 1'b1;
               n_ff       <= n_ff + 1'b1;
            end
            ST_REINSERT: count_ff <= count_ff + 1'b1;
            ST_EMIT: begin
               if (emit_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '{
                     kind:            res_kind_ff,
                     expired_tag:     res_tag_ff,
                     next_deadline_s: ent_w[0].valid ? ent_w[0].dl : 32'd0,
                     has_pending:     count_ff != '0,
                     pending_count:   cnt_wide[RES_CNT_W-1:0],
                     last:            res_last_ff
                  };
               end
            end
            default: ;
         endcase
      end
   end

   assign cnt_wide  = 32'(count_ff);
   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `SDTQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept && req_data.op != OP_UNUSED, state_ff != ST_IDLE)
   `SDTQ_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_TIMERS))
   `SDTQ_ASSERT_IMP(a_head_matches_count, clock, reset, 1'b1, (count_ff == '0) == !ent_w[0].valid)
   `SDTQ_ASSERT_IMP(a_fire_cap, clock, reset, 1'b1, n_ff <= RES_CNT_W'(RESULT_CAP))

endmodule

@@ test/sorted_deadline_timer_queue_test.sv @@
// Self-checking bench for the sorted deadline timer queue: a queue of pending
// items feeds a clocked driver; a clocked monitor checks each result item.
// Depends on sdtq_pkg and the sorted_deadline_timer_queue RTL.
`timescale 1ns / 1ps
module sorted_deadline_timer_queue_test;
   import sdtq_pkg::*;

   localparam int SLOTS = 16;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   sorted_deadline_timer_queue dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------- timer queue shadow ----------------
   logic [31:0] q_dl [SLOTS];
   logic [31:0] q_iv [SLOTS];
   logic [15:0] q_tag [SLOTS];
   logic        q_fired [SLOTS];
   int          q_count = 0;

   rsp_item_type expected_rsp[$];
   req_item_type pending_items[$];

   int errors = 0;
   int accepted_items = 0;
   int checked_rsp = 0;
   int expired_seen = 0;
   int full_seen = 0;
   int idle_cycles = 0;

   function automatic bit later_than(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d != 0) && !d[31];
   endfunction

   function automatic void drop_slot(int pos);
      for (int i = pos; i + 1 < q_count; i++) begin
         q_dl[i] = q_dl[i+1];
         q_iv[i] = q_iv[i+1];
         q_tag[i] = q_tag[i+1];
         q_fired[i] = q_fired[i+1];
      end
      q_count--;
   endfunction

   function automatic void place_timer(logic [31:0] dl, logic [31:0] iv,
                                       logic [15:0] tag, bit fired);
      int pos;
      pos = q_count;
      for (int i = 0; i < q_count; i++) begin
         if (later_than(q_dl[i], dl)) begin
            pos = i;
            break;
         end
      end
      for (int i = q_count; i > pos; i--) begin
         q_dl[i] = q_dl[i-1];
         q_iv[i] = q_iv[i-1];
         q_tag[i] = q_tag[i-1];
         q_fired[i] = q_fired[i-1];
      end
      q_dl[pos] = dl;
      q_iv[pos] = iv;
      q_tag[pos] = tag;
      q_fired[pos] = fired;
      q_count++;
   endfunction

   function automatic rsp_item_type snapshot(logic [2:0] kind, logic [15:0] tag);
      rsp_item_type r;
      r.kind = kind;
      r.expired_tag = tag;
      r.next_deadline_s = (q_count > 0) ? q_dl[0] : 32'd0;
      r.has_pending = (q_count > 0);
      r.pending_count = q_count[4:0];
      r.last = 1'b0;
      return r;
   endfunction

   // Works out the result items of one accepted item and queues them.
   function automatic void predict_timer_results(req_item_type it);
      rsp_item_type batch[$];
      int pos;
      logic [31:0] d, v;
      logic [15:0] t;
      bit found;
      case (it.op)
         OP_ARM: begin
            if (q_count >= SLOTS) batch.push_back(snapshot(KIND_FULL, 16'd0));
            else begin
               place_timer(it.deadline_s, it.repeat_ms, it.timer_tag, 1'b0);
               batch.push_back(snapshot(KIND_ARMED, 16'd0));
            end
         end
         OP_CANCEL: begin
            found = 1'b0;
            for (int i = 0; i < q_count; i++) begin
               if (q_tag[i] == it.timer_tag) begin
                  drop_slot(i);
                  found = 1'b1;
                  break;
               end
            end
            batch.push_back(snapshot(found ? KIND_CANCELLED : KIND_NOT_FOUND, 16'd0));
         end
         OP_TICK: begin
            for (int i = 0; i < SLOTS; i++) q_fired[i] = 1'b0;
            while (batch.size() < RESULT_CAP) begin
               pos = q_count;
               for (int i = 0; i < q_count; i++) begin
                  if (!q_fired[i]) begin
                     pos = i;
                     break;
                  end
               end
               if (pos >= q_count || later_than(q_dl[pos], it.now_s)) break;
               d = q_dl[pos];
               v = q_iv[pos];
               t = q_tag[pos];
               drop_slot(pos);
               // repeat interval rounded to whole seconds
               if (v != 0) place_timer(d + v / 1000 + ((v % 1000) >= 500 ? 1 : 0),
                                       v, t, 1'b1);
               batch.push_back(snapshot(KIND_EXPIRED, t));
            end
            if (batch.size() == 0) batch.push_back(snapshot(KIND_NONE, 16'd0));
         end
         default: ; // unused op: no result
      endcase
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) expected_rsp.push_back(batch[i]);
   endfunction

   // ---------------- stimulus construction ----------------
   function automatic req_item_type mk(logic [1:0] op, logic [15:0] tag,
                                      logic [31:0] dl, logic [31:0] rep,
                                      logic [31:0] now);
      req_item_type it;
      it.op = op;
      it.timer_tag = tag;
      it.deadline_s = dl;
      it.repeat_ms = rep;
      it.now_s = now;
      return it;
   endfunction

   // random fill for fields the op does not use
   function automatic req_item_type noisy(req_item_type it);
      if (it.op != OP_ARM) begin
         it.deadline_s = $urandom;
         it.repeat_ms = $urandom;
      end
      if (it.op != OP_TICK) it.now_s = $urandom;
      if (it.op == OP_TICK) it.timer_tag = $urandom;
      return it;
   endfunction

   logic [31:0] clock_s;   // running wall time for well-formed scenarios
   bit hold_for_drain = 1'b0;
   int drain_at;

   initial begin : build_items
      logic [15:0] tg;
      int pick;
      clock_s = 32'h7FFF_FFF0;
      // Directed: every op, the extremes, the special cases.
      pending_items.push_back(mk(OP_TICK, 16'h0, 0, 0, 32'h0));          // empty tick
      pending_items.push_back(mk(OP_CANCEL, 16'hFFFF, 0, 0, 0));          // miss, empty
      pending_items.push_back(mk(OP_ARM, 16'h0000, 32'h0, 32'h0, 0));     // one-shot
      pending_items.push_back(mk(OP_ARM, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
      pending_items.push_back(mk(OP_ARM, 16'h1234, 32'h0, 32'd499, 0));   // rounds to 0
      pending_items.push_back(mk(OP_ARM, 16'h1235, 32'h0, 32'd500, 0));   // rounds up
      pending_items.push_back(mk(OP_ARM, 16'h1236, 32'h8000_0000, 32'd1499, 0));
      pending_items.push_back(mk(OP_UNUSED, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                 32'h5555_5555));
      pending_items.push_back(mk(OP_TICK, 0, 0, 0, 32'h0));               // wrap compare
      pending_items.push_back(mk(OP_TICK, 0, 0, 0, 32'h7FFF_FFFF));
      pending_items.push_back(mk(OP_CANCEL, 16'h1234, 0, 0, 0));
      pending_items.push_back(mk(OP_CANCEL, 16'h5555, 0, 0, 0));
      for (int i = 0; i < 17; i++)                                        // fill to full
         pending_items.push_back(mk(OP_ARM, 16'h0100 + i[15:0], 32'd10, 32'd200, 0));
      pending_items.push_back(mk(OP_TICK, 0, 0, 0, 32'd10));              // many expiries
      pending_items.push_back(mk(OP_TICK, 0, 0, 0, 32'hFFFF_FFFF));
      drain_at = pending_items.size();
      // Random: mostly arms and ticks around a moving time, some noise.
      for (int n = 0; n < 450; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            tg = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 31));
            pending_items.push_back(noisy(mk(OP_ARM, tg,
               ($urandom_range(0, 9) == 0) ? 32'($urandom) : clock_s + $urandom_range(0, 6),
               ($urandom_range(0, 2) == 0) ? 32'd0 :
               ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 4000)),
               0)));
         end else if (pick < 60) begin
            pending_items.push_back(noisy(mk(OP_CANCEL,
               ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 31)),
               0, 0, 0)));
         end else if (pick < 97) begin
            clock_s = clock_s + $urandom_range(0, 3);
            pending_items.push_back(noisy(mk(OP_TICK, 0, 0, 0,
               ($urandom_range(0, 19) == 0) ? 32'($urandom) : clock_s)));
         end else begin
            pending_items.push_back(noisy(mk(OP_UNUSED, 0, 0, 0, 0)));
         end
      end
   end

   // ---------------- clock, reset, driver ----------------
   int cyc = 0;
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // quiet window with no idling on either side
   function automatic bit may_idle();
      return !(cyc > 2000 && cyc < 3500) && ($urandom_range(0, 99) < 20);
   endfunction

   int sent = 0;
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (!reset) begin
         rsp_stall <= may_idle();
         if (req_valid && !req_stall) begin
            accepted_items++;
            predict_timer_results(req_data);
         end
         if (!req_valid || !req_stall) begin
            // sender pauses once until every expected result has come
            if (sent == drain_at && !hold_for_drain && expected_rsp.size() != 0
                && !(req_valid && !req_stall) == 0) hold_for_drain = 1'b1;
            if (hold_for_drain && expected_rsp.size() == 0 && !(req_valid && !req_stall))
               hold_for_drain = 1'b0;
            if (pending_items.size() > 0 && !hold_for_drain && !may_idle()) begin
               req_data <= pending_items.pop_front();
               req_valid <= 1'b1;
               sent++;
               if (sent == drain_at) hold_for_drain = 1'b1;
            end else req_valid <= 1'b0;
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         checked_rsp++;
         if (expected_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result item %p", rsp_data);
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_data.kind == KIND_EXPIRED) expired_seen++;
            if (rsp_data.kind == KIND_FULL) full_seen++;
            if (rsp_data !== e) begin
               errors++;
               if (errors <= 10)
                  $display("result %0d mismatch: expected %p got %p",
                           checked_rsp, e, rsp_data);
            end
         end
      end
   end

   // watchdog on cycles where nothing moves
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin : finish_run
      @(negedge reset);
      while ((pending_items.size() > 0 || req_valid || expected_rsp.size() > 0)
             && idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress, %0d results still expected", expected_rsp.size());
         $display("Simulation FAILED");
         $finish;
      end else begin
         repeat (100) @(posedge clock);
         $display("Covered %0d items and %0d result items (%0d expirations, %0d full).",
                  accepted_items, checked_rsp, expired_seen, full_seen);
         if (errors == 0 && expected_rsp.size() == 0) $display("Simulation PASSED");
         else $display("Simulation FAILED");
         $finish;
      end
   end
endmodule
